// File: hw/rtl/afr_pkg.sv
// Package for the addressed frame receiver: frame constants, status codes,
// register indexes, result type and the byte-wide CRC-16 update.
// No dependencies.
package afr_pkg;

    localparam int unsigned POS_W = 9;

    localparam logic [7:0]       HDR_FIRST     = 8'h18;
    localparam logic [7:0]       HDR_SECOND    = 8'h02;
    localparam logic [7:0]       TERM_FIRST    = 8'hE7;
    localparam logic [7:0]       TERM_SECOND   = 8'hFD;
    localparam logic [15:0]      CRC_POLY      = 16'h1021;
    localparam logic [POS_W-1:0] FRAME_OVHD    = 9'd9;
    localparam logic [POS_W-1:0] LEN_ZERO_AS   = 9'd256;
    localparam logic [POS_W-1:0] POS_LEN_BYTE  = 9'd4;
    localparam logic [POS_W-1:0] POS_PAYLOAD   = 9'd5;
    localparam logic [7:0]       STATION_RESET = 8'h0A;
    localparam logic [15:0]      CRC_RESET     = 16'hFFFF;

    localparam logic REG_STATION  = 1'b0;
    localparam logic REG_CRC_INIT = 1'b1;

    typedef enum logic [2:0] {
        ST_VALID       = 3'd0,
        ST_BAD_HEADER  = 3'd1,
        ST_WRONG_DEST  = 3'd2,
        ST_BAD_CRC     = 3'd3,
        ST_BAD_TERM    = 3'd4,
        ST_TIMEOUT     = 3'd5
    } status_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        status_t    frame_status;
        logic [7:0] source_station;
    } result_t;

    typedef struct packed {
        logic [7:0]  station_address;
        logic [15:0] crc_initial;
    } cfg_t;

    // CRC-16, MSB first, no reflection
    function automatic logic [15:0] crc_feed(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/afr_if.sv
// Valid/ready channel interfaces for the frame receiver's input and result items.
// No dependencies.
interface afr_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, mode, rx_byte, input ready);
    modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface afr_out_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] frame_status;
    logic [7:0] source_station;

    modport source (output valid, is_status, payload_byte, payload_index, frame_status,
                    source_station, input ready);
    modport sink   (input valid, is_status, payload_byte, payload_index, frame_status,
                    source_station, output ready);
endinterface

// File: hw/rtl/afr_regs.sv
// APB configuration registers: station address and CRC initial value.
// Depends on afr_pkg.
module afr_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output afr_pkg::cfg_t cfg
);

    logic [7:0]  station_reg;
    logic [15:0] crc_init_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg  <= afr_pkg::STATION_RESET;
            crc_init_reg <= afr_pkg::CRC_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == afr_pkg::REG_STATION)
            begin
                station_reg <= pwdata[7:0];
            end
            else
            begin
                crc_init_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == afr_pkg::REG_STATION)
        begin
            prdata = {24'h000000, station_reg};
        end
        else
        begin
            prdata = {16'h0000, crc_init_reg};
        end
    end

    assign cfg.station_address = station_reg;
    assign cfg.crc_initial     = crc_init_reg;

endmodule

// File: hw/rtl/afr_ctl.sv
// Frame tracker: byte position, header/address/CRC/terminator checks and the
// result for one item. Depends on afr_pkg.
module afr_ctl (
    input  logic             clk,
    input  logic             rst_n,
    input  afr_pkg::cfg_t    cfg,
    input  logic             step,
    input  logic             mode,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output afr_pkg::result_t res,
    output logic             frame_active
);

    localparam int unsigned PW = afr_pkg::POS_W;

    logic [PW-1:0] pos_reg,       pos_next;
    logic [PW-1:0] len_reg,       len_next;
    logic [15:0]   crc_reg,       crc_next;
    logic          hdr_good_reg,  hdr_good_next;
    logic          addr_good_reg, addr_good_next;
    logic [7:0]    src_reg,       src_next;
    logic [7:0]    crc_hi_reg,    crc_hi_next;
    logic          crc_good_reg,  crc_good_next;
    logic          term_good_reg, term_good_next;

    logic [15:0]   crc_src;
    logic [15:0]   crc_upd;
    logic [PW-1:0] pos_p4, pos_p3, pos_p2, pos_idx;
    logic [PW-1:0] len_byte;

    assign crc_src  = (pos_reg == '0) ? cfg.crc_initial : crc_reg;
    assign crc_upd  = afr_pkg::crc_feed(crc_src, rx_byte);
    assign pos_p4   = pos_reg + PW'(4);
    assign pos_p3   = pos_reg + PW'(3);
    assign pos_p2   = pos_reg + PW'(2);
    assign pos_idx  = pos_reg - afr_pkg::POS_PAYLOAD;
    assign len_byte = ((rx_byte == 8'h00) ? afr_pkg::LEN_ZERO_AS : {1'b0, rx_byte})
                      + afr_pkg::FRAME_OVHD;
    assign frame_active = (pos_reg != '0);

    always_comb
    begin
        pos_next       = pos_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        hdr_good_next  = hdr_good_reg;
        addr_good_next = addr_good_reg;
        src_next       = src_reg;
        crc_hi_next    = crc_hi_reg;
        crc_good_next  = crc_good_reg;
        term_good_next = term_good_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (mode)
        begin
            if (pos_reg != '0)
            begin
                pos_next           = '0;
                res_valid          = 1'b1;
                res.is_status      = 1'b1;
                res.frame_status   = afr_pkg::ST_TIMEOUT;
                res.source_station = src_reg;
            end
        end
        else if (pos_reg == '0)
        begin
            hdr_good_next  = (rx_byte == afr_pkg::HDR_FIRST);
            addr_good_next = 1'b1;
            src_next       = 8'h00;
            crc_hi_next    = 8'h00;
            crc_good_next  = 1'b0;
            term_good_next = 1'b0;
            len_next       = '0;
            crc_next       = crc_upd;
            pos_next       = PW'(1);
        end
        else if (pos_reg <= afr_pkg::POS_LEN_BYTE)
        begin
            crc_next = crc_upd;
            pos_next = pos_reg + PW'(1);
            if (pos_reg == PW'(1))
            begin
                hdr_good_next = hdr_good_reg && (rx_byte == afr_pkg::HDR_SECOND);
            end
            else if (pos_reg == PW'(2))
            begin
                addr_good_next = (rx_byte == cfg.station_address);
            end
            else if (pos_reg == PW'(3))
            begin
                src_next = rx_byte;
            end
            else
            begin
                len_next = len_byte;
            end
        end
        else if (pos_p4 < len_reg)
        begin
            crc_next          = crc_upd;
            pos_next          = pos_reg + PW'(1);
            res_valid         = 1'b1;
            res.payload_byte  = rx_byte;
            res.payload_index = pos_idx[7:0];
        end
        else if (pos_p4 == len_reg)
        begin
            crc_hi_next = rx_byte;
            pos_next    = pos_reg + PW'(1);
        end
        else if (pos_p3 == len_reg)
        begin
            crc_good_next = ({crc_hi_reg, rx_byte} == crc_reg);
            pos_next      = pos_reg + PW'(1);
        end
        else if (pos_p2 == len_reg)
        begin
            term_good_next = (rx_byte == afr_pkg::TERM_FIRST);
            pos_next       = pos_reg + PW'(1);
        end
        else
        begin
            pos_next           = '0;
            res_valid          = 1'b1;
            res.is_status      = 1'b1;
            res.source_station = src_reg;
            if (!hdr_good_reg)
            begin
                res.frame_status = afr_pkg::ST_BAD_HEADER;
            end
            else if (!addr_good_reg)
            begin
                res.frame_status = afr_pkg::ST_WRONG_DEST;
            end
            else if (!crc_good_reg)
            begin
                res.frame_status = afr_pkg::ST_BAD_CRC;
            end
            else if (!(term_good_reg && (rx_byte == afr_pkg::TERM_SECOND)))
            begin
                res.frame_status = afr_pkg::ST_BAD_TERM;
            end
            else
            begin
                res.frame_status = afr_pkg::ST_VALID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            crc_reg       <= afr_pkg::CRC_RESET;
            hdr_good_reg  <= 1'b1;
            addr_good_reg <= 1'b1;
            src_reg       <= 8'h00;
            crc_hi_reg    <= 8'h00;
            crc_good_reg  <= 1'b0;
            term_good_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            hdr_good_reg  <= hdr_good_next;
            addr_good_reg <= addr_good_next;
            src_reg       <= src_next;
            crc_hi_reg    <= crc_hi_next;
            crc_good_reg  <= crc_good_next;
            term_good_reg <= term_good_next;
        end
    end

endmodule

// File: hw/rtl/addressed_frame_receiver.sv
// Top level of the addressed frame receiver: input register, frame tracker,
// result register and APB registers. Depends on afr_pkg, afr_if, afr_regs, afr_ctl.
//
// Takes one item (received byte or timeout event) per clock cycle unless stalled.
// An accepted item waits in the input register until the frame tracker takes it;
// its result (a payload byte with its index, or one end-of-frame status with the
// source station) goes through the result register to the output channel. Header,
// address, source, length, CRC and first terminator bytes produce no result, and a
// timeout with no frame in progress is dropped. The result register decouples the
// two sides; input stalls only while a result is waiting and the input register
// is full. crc_initial is loaded at the first byte of each frame.
module addressed_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,
    afr_in_if.sink       in_ch,
    afr_out_if.source    out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    afr_pkg::cfg_t    cfg;
    afr_pkg::result_t res;
    afr_pkg::result_t out_res_reg;
    logic             res_valid;
    logic             frame_active;
    logic             in_vld_reg;
    logic             in_mode_reg;
    logic [7:0]       in_byte_reg;
    logic             out_vld_reg;
    logic             advance;
    logic             in_take;

    assign advance     = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    afr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afr_ctl u_ctl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step         (advance),
        .mode         (in_mode_reg),
        .rx_byte      (in_byte_reg),
        .res_valid    (res_valid),
        .res          (res),
        .frame_active (frame_active)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_vld_reg <= res_valid;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg <= in_ch.mode;
            in_byte_reg <= in_ch.rx_byte;
        end
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.is_status      = out_res_reg.is_status;
    assign out_ch.payload_byte   = out_res_reg.payload_byte;
    assign out_ch.payload_index  = out_res_reg.payload_index;
    assign out_ch.frame_status   = out_res_reg.frame_status;
    assign out_ch.source_station = out_res_reg.source_station;

`ifndef ASSERT_OFF
    a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> in_ch.ready)
        else $error("input stalled with result register empty");

    a_idle_timeout_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_mode_reg && !frame_active) |=> !out_vld_reg)
        else $error("timeout outside a frame produced a result");

    a_result_registered: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid) |=> out_vld_reg)
        else $error("result lost on the way to the output register");

    a_timeout_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_mode_reg) |=> !frame_active)
        else $error("frame still active after timeout");
`endif

endmodule

// File: dv/tb_addressed_frame_receiver.sv
// Testbench for addressed_frame_receiver: queued byte/timeout items drive the input channel,
// a frame tracker in the bench predicts payload and status results, and a monitor checks them.
// Depends on afr_pkg, afr_if and the addressed_frame_receiver RTL.
module tb_addressed_frame_receiver;

    localparam int unsigned LIMIT_CYCLES  = 300000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES   = 300;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } in_item_t;

    typedef enum int {
        FL_NONE, FL_HDR0, FL_HDR1, FL_DEST, FL_CRC_HI, FL_CRC_LO,
        FL_TERM0, FL_TERM1, FL_STACKED, FL_CUT
    } flaw_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    afr_in_if  in_if ();
    afr_out_if out_if ();

    addressed_frame_receiver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // register mirror
    logic [7:0]  cfg_station  = afr_pkg::STATION_RESET;
    logic [15:0] cfg_crc_init = afr_pkg::CRC_RESET;

    // frame tracker state
    logic [8:0]  pos_q    = '0;
    logic [8:0]  flen_q   = '0;
    logic [15:0] crc_q    = afr_pkg::CRC_RESET;
    logic        hdr_ok   = 1'b1;
    logic        addr_ok  = 1'b1;
    logic [7:0]  src_q    = '0;
    logic [7:0]  crc_hi_q = '0;
    logic        crc_ok   = 1'b0;
    logic        term1_ok = 1'b0;

    in_item_t          send_queue[$];
    afr_pkg::result_t  pending_results[$];
    in_item_t          cur_item;

    int unsigned items_queued = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;
    int unsigned tx_wait      = 0;
    int unsigned rx_wait      = 0;
    int unsigned hold_left    = 0;
    bit          drv_active   = 0;
    bit          in_taken     = 0;
    bit          out_taken    = 0;
    bit          hold_req     = 0;
    bit          calm         = 0;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        logic        fb;
        int          i;
        x = c;
        for (i = 7; i >= 0; i--)
        begin
            fb = x[15] ^ d[i];
            x = {x[14:0], 1'b0};
            if (fb)
            begin
                x = x ^ afr_pkg::CRC_POLY;
            end
        end
        return x;
    endfunction

    function automatic logic [7:0] nz_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic track_frame(input in_item_t it);
        afr_pkg::result_t r;
        logic [8:0]       idx;
        r = '0;
        if (it.mode)
        begin
            if (pos_q != 9'd0)
            begin
                pos_q = '0;
                r.is_status = 1'b1;
                r.frame_status = afr_pkg::ST_TIMEOUT;
                r.source_station = src_q;
                pending_results.push_back(r);
            end
        end
        else if (pos_q == 9'd0)
        begin
            hdr_ok   = (it.data == afr_pkg::HDR_FIRST);
            addr_ok  = 1'b1;
            src_q    = '0;
            crc_hi_q = '0;
            crc_ok   = 1'b0;
            term1_ok = 1'b0;
            flen_q   = '0;
            crc_q    = crc_step(cfg_crc_init, it.data);
            pos_q    = 9'd1;
        end
        else if (pos_q <= afr_pkg::POS_LEN_BYTE)
        begin
            crc_q = crc_step(crc_q, it.data);
            case (pos_q)
                9'd1: hdr_ok = hdr_ok && (it.data == afr_pkg::HDR_SECOND);
                9'd2: addr_ok = (it.data == cfg_station);
                9'd3: src_q = it.data;
                default: flen_q = ((it.data == 8'd0) ? afr_pkg::LEN_ZERO_AS : {1'b0, it.data})
                                  + afr_pkg::FRAME_OVHD;
            endcase
            pos_q = pos_q + 9'd1;
        end
        else if (pos_q + 9'd4 < flen_q)
        begin
            crc_q = crc_step(crc_q, it.data);
            idx = pos_q - afr_pkg::POS_PAYLOAD;
            r.payload_byte = it.data;
            r.payload_index = idx[7:0];
            r.frame_status = afr_pkg::ST_VALID;
            pending_results.push_back(r);
            pos_q = pos_q + 9'd1;
        end
        else if (pos_q + 9'd4 == flen_q)
        begin
            crc_hi_q = it.data;
            pos_q = pos_q + 9'd1;
        end
        else if (pos_q + 9'd3 == flen_q)
        begin
            crc_ok = ({crc_hi_q, it.data} == crc_q);
            pos_q = pos_q + 9'd1;
        end
        else if (pos_q + 9'd2 == flen_q)
        begin
            term1_ok = (it.data == afr_pkg::TERM_FIRST);
            pos_q = pos_q + 9'd1;
        end
        else
        begin
            r.is_status = 1'b1;
            r.source_station = src_q;
            if (!hdr_ok)
                r.frame_status = afr_pkg::ST_BAD_HEADER;
            else if (!addr_ok)
                r.frame_status = afr_pkg::ST_WRONG_DEST;
            else if (!crc_ok)
                r.frame_status = afr_pkg::ST_BAD_CRC;
            else if (!(term1_ok && it.data == afr_pkg::TERM_SECOND))
                r.frame_status = afr_pkg::ST_BAD_TERM;
            else
                r.frame_status = afr_pkg::ST_VALID;
            pending_results.push_back(r);
            pos_q = '0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_item(input logic mode, input logic [7:0] data);
        in_item_t it;
        it.mode = mode;
        it.data = data;
        send_queue.push_back(it);
        items_queued++;
    endtask

    // plen 1..256; a cut frame stops after cut_at bytes and ends with a timeout
    task automatic queue_frame(input int unsigned plen, input flaw_t flaw,
                               input int unsigned cut_at);
        logic [7:0]  fr[$];
        logic [15:0] c;
        int unsigned i;
        fr.push_back((flaw == FL_HDR0) ? (afr_pkg::HDR_FIRST ^ nz_byte()) : afr_pkg::HDR_FIRST);
        fr.push_back((flaw == FL_HDR1 || flaw == FL_STACKED)
                     ? (afr_pkg::HDR_SECOND ^ nz_byte()) : afr_pkg::HDR_SECOND);
        fr.push_back((flaw == FL_DEST || flaw == FL_STACKED) ? (cfg_station ^ nz_byte())
                                                              : cfg_station);
        fr.push_back(8'($urandom));
        fr.push_back(8'(plen));
        for (i = 0; i < plen; i++)
        begin
            fr.push_back(8'($urandom));
        end
        c = cfg_crc_init;
        foreach (fr[k])
        begin
            c = crc_step(c, fr[k]);
        end
        if (flaw == FL_CRC_HI || flaw == FL_STACKED)
            c[15:8] = c[15:8] ^ nz_byte();
        if (flaw == FL_CRC_LO)
            c[7:0] = c[7:0] ^ nz_byte();
        fr.push_back(c[15:8]);
        fr.push_back(c[7:0]);
        fr.push_back((flaw == FL_TERM0) ? (afr_pkg::TERM_FIRST ^ nz_byte())
                                        : afr_pkg::TERM_FIRST);
        fr.push_back((flaw == FL_TERM1) ? (afr_pkg::TERM_SECOND ^ nz_byte())
                                        : afr_pkg::TERM_SECOND);
        if (flaw == FL_CUT)
        begin
            for (i = 0; i < cut_at; i++)
            begin
                push_item(1'b0, fr[i]);
            end
            push_item(1'b1, 8'($urandom));
        end
        else
        begin
            foreach (fr[k])
            begin
                push_item(1'b0, fr[k]);
            end
        end
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == afr_pkg::REG_STATION)
            cfg_station = data[7:0];
        else
            cfg_crc_init = data[15:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        while (send_queue.size() != 0 || drv_active || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] station, input logic [15:0] crc,
                             input int unsigned n_items, input bit with_hold,
                             input int unsigned big_frames);
        int unsigned stop_at;
        int unsigned sel;
        int unsigned plen;
        int unsigned n;
        int unsigned i;
        flaw_t       flaw;
        reg_write(afr_pkg::REG_STATION, {24'd0, station});
        reg_write(afr_pkg::REG_CRC_INIT, {16'd0, crc});
        stop_at = items_queued + n_items;
        if (with_hold)
        begin
            hold_req = 1;
            queue_frame(60, FL_NONE, 0);
        end
        for (i = 0; i < big_frames; i++)
        begin
            queue_frame(256, (i == 0) ? FL_NONE : FL_CRC_LO, 0);
        end
        while (items_queued < stop_at)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                plen = $urandom_range(1, 12);
            else if (sel < 93)
                plen = $urandom_range(13, 64);
            else if (sel < 98)
                plen = $urandom_range(65, 254);
            else
                plen = 255;
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                queue_frame(plen, FL_NONE, 0);
            end
            else if (sel < 92)
            begin
                flaw = flaw_t'($urandom_range(FL_HDR0, FL_CUT));
                queue_frame(plen, flaw, $urandom_range(0, plen + 8));
            end
            else
            begin
                // noise, then a timeout to get back in step
                n = $urandom_range(1, 20);
                for (i = 0; i < n; i++)
                begin
                    push_item($urandom_range(0, 7) == 0, 8'($urandom));
                end
                push_item(1'b1, 8'($urandom));
            end
        end
        settle();
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                in_taken = 0;
                drv_active = 0;
            end
            if (!drv_active)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                end
                else if (send_queue.size() > 0)
                begin
                    cur_item = send_queue.pop_front();
                    in_if.mode    <= cur_item.mode;
                    in_if.rx_byte <= cur_item.data;
                    drv_active = 1;
                    tx_wait = calm ? 0 : $urandom_range(0, 9);
                end
            end
            in_if.valid <= drv_active;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 0;
                rx_wait = calm ? 0 : $urandom_range(0, 9);
            end
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            else if (out_if.valid && rx_wait > 0)
                rx_wait--;
            out_if.ready <= (hold_left == 0) && (rx_wait == 0);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        afr_pkg::result_t want;
        in_item_t         got_in;
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                out_taken = 1;
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing pending: is_status %0d status %0d",
                           out_if.is_status, out_if.frame_status);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("is_status", want.is_status, out_if.is_status);
                    check_field("payload_byte", want.payload_byte, out_if.payload_byte);
                    check_field("payload_index", want.payload_index, out_if.payload_index);
                    check_field("frame_status", want.frame_status, out_if.frame_status);
                    check_field("source_station", want.source_station, out_if.source_station);
                end
            end
            if (in_if.valid && in_if.ready)
            begin
                in_taken = 1;
                got_in.mode = in_if.mode;
                got_in.data = in_if.rx_byte;
                track_frame(got_in);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_if.valid    = 1'b0;
        in_if.mode     = 1'b0;
        in_if.rx_byte  = '0;
        out_if.ready   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle timeout, minimal good frame, timeouts before and after source
        push_item(1'b1, 8'hFF);
        queue_frame(1, FL_NONE, 0);
        queue_frame(1, FL_CUT, 2);
        queue_frame(1, FL_CUT, 4);
        settle();

        run_phase(8'h00, 16'h0000, 290, 0, 0);
        run_phase(8'hFF, 16'hFFFF, 290, 1, 1);
        calm = 1;
        run_phase(8'($urandom), 16'($urandom), 290, 0, 0);
        calm = 0;
        run_phase(8'($urandom), 16'h1D0F, 290, 0, 1);
        run_phase(afr_pkg::STATION_RESET, afr_pkg::CRC_RESET, 290, 0, 0);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/afr_pkg.sv
hw/rtl/afr_if.sv
hw/rtl/afr_regs.sv
hw/rtl/afr_ctl.sv
hw/rtl/addressed_frame_receiver.sv
dv/tb_addressed_frame_receiver.sv
